### sv/tra_pkg.sv
`timescale 1ns / 1ps
package tra_pkg;
    localparam int TableEntries = 1024;
    localparam int FreeSlots = 16;
    localparam int IdxW = $clog2(TableEntries);
    localparam int FreeW = $clog2(FreeSlots);
    localparam int CntW = $clog2(FreeSlots + 1);
    localparam int FreshW = $clog2(TableEntries + 1);
    localparam int EntryW = 17;
    localparam int SizeW = 7;

    localparam logic [13:0] TileFirst = 14'd1001;
    localparam logic [13:0] TileLast = 14'd1100;
    localparam logic [3:0] UvLimit = 4'd10;

    typedef enum logic [2:0] {
        REQ_ALLOC = 3'd0,
        REQ_SET = 3'd1,
        REQ_FREE = 3'd2,
        REQ_RES_ID = 3'd3,
        REQ_RES_UV = 3'd4
    } req_t;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_TABLE_FULL = 3'd1;
    localparam logic [2:0] ST_FREE_FULL = 3'd2;
    localparam logic [2:0] ST_ILLEGAL_ID = 3'd3;
    localparam logic [2:0] ST_BEYOND = 3'd4;
    localparam logic [2:0] ST_EMPTY = 3'd5;
    localparam logic [2:0] ST_UV_RANGE = 3'd6;
endpackage

### sv/tra_ram.sv
`timescale 1ns / 1ps
module tra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### sv/tile_range_allocator_top.sv
`timescale 1ns / 1ps
// Best-fit tile range allocator. Each request (one s_axis transaction) yields
// exactly one result transaction on m_axis. Tile entries and range sizes sit in
// synchronous single-port-read RAMs, the free list in a small RAM; every read
// is registered, so requests run through a sequencer one at a time. After
// reset a clearing pass walks both tables, one entry a cycle, before the first
// request is taken. An allocate examines up to 16 free slots, a free clears up
// to 127 entries. The result register lets the next request enter while a
// result still waits.
module tile_range_allocator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // req_type[2:0], range_size[9:3], range_start[19:10], tile_id[33:20],
    // u_tile[37:34], v_tile[41:38], texture_handle[57:42], zero pad [63:58]
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], alloc_start[12:3], found_handle[28:13], handle_valid[29],
    // zero pad [31:30]
    output logic [31:0] m_axis_tdata
);
    import tra_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOC, S_LOC_WAIT, S_LOC_CHK, S_RES,
        S_AL_RD, S_AL_WAIT, S_AL_SZ, S_AL_CMP, S_AL_DONE, S_AL_MOVE,
        S_FR_SZ, S_FR_CLR, S_OUT
    } state_t;

    state_t state_reg;
    logic [2:0] req_reg;
    logic [SizeW-1:0] size_reg;
    logic [IdxW-1:0] start_reg;
    logic [13:0] tile_reg;
    logic [15:0] handle_reg;
    logic [IdxW-1:0] ptr_reg;
    logic [IdxW:0] end_reg;
    logic [CntW-1:0] fcount_reg;
    logic [FreshW-1:0] fresh_reg;
    logic [CntW-1:0] scan_reg;
    logic [FreeW-1:0] best_reg;
    logic best_hit_reg;
    logic [SizeW:0] best_size_reg;
    logic [IdxW-1:0] cand_reg;
    logic [FreeW-1:0] mv_dst_reg;
    logic [2:0] st_reg;
    logic [IdxW-1:0] ast_reg;
    logic [15:0] fh_reg;
    logic hv_reg;
    logic out_valid_reg;
    logic [2:0] o_st_reg;
    logic [IdxW-1:0] o_ast_reg;
    logic [15:0] o_fh_reg;
    logic o_hv_reg;

    // RAM ports
    logic te_we, rs_we, fs_we;
    logic [IdxW-1:0] te_wa, te_ra, rs_wa, rs_ra;
    logic [EntryW-1:0] te_wd, te_rd;
    logic [SizeW-1:0] rs_wd, rs_rd;
    logic [FreeW-1:0] fs_wa, fs_ra;
    logic [IdxW-1:0] fs_wd, fs_rd;

    tra_ram #(.WIDTH(EntryW), .DEPTH(TableEntries)) u_entries (
        .clk(clk), .we(te_we), .waddr(te_wa), .wdata(te_wd), .raddr(te_ra), .rdata(te_rd));
    tra_ram #(.WIDTH(SizeW), .DEPTH(TableEntries)) u_sizes (
        .clk(clk), .we(rs_we), .waddr(rs_wa), .wdata(rs_wd), .raddr(rs_ra), .rdata(rs_rd));
    tra_ram #(.WIDTH(IdxW), .DEPTH(FreeSlots)) u_free (
        .clk(clk), .we(fs_we), .waddr(fs_wa), .wdata(fs_wd), .raddr(fs_ra), .rdata(fs_rd));

    // Input field slices
    logic [2:0] in_req;
    logic [SizeW-1:0] in_size;
    logic [IdxW-1:0] in_start;
    logic [13:0] in_tile;
    logic [3:0] in_u, in_v;
    logic [15:0] in_handle;
    assign in_req = s_axis_tdata[2:0];
    assign in_size = s_axis_tdata[9:3];
    assign in_start = s_axis_tdata[19:10];
    assign in_tile = s_axis_tdata[33:20];
    assign in_u = s_axis_tdata[37:34];
    assign in_v = s_axis_tdata[41:38];
    assign in_handle = s_axis_tdata[57:42];

    logic accept;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;

    // uv mapped to a tile number: 1001 + u + 10*v
    logic [13:0] uv_tile;
    assign uv_tile = TileFirst + 14'(in_u) + 14'({in_v, 3'b000}) + 14'({in_v, 1'b0});

    // locate: offset and position
    logic [13:0] tile_off;
    logic tile_bad;
    logic [IdxW:0] loc_pos;
    assign tile_off = tile_reg - TileFirst;
    assign tile_bad = (tile_reg < TileFirst) || (tile_reg > TileLast);
    assign loc_pos = {1'b0, start_reg} + (IdxW + 1)'(tile_off[6:0]);

    logic [SizeW-1:0] need;
    assign need = (size_reg == '0) ? SizeW'(1) : size_reg;
    logic [FreshW:0] fresh_end;
    assign fresh_end = {1'b0, fresh_reg} + (FreshW + 1)'(need);

    logic result_free;
    assign result_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        te_we = 1'b0;
        te_wa = ptr_reg;
        te_wd = '0;
        te_ra = ptr_reg;
        rs_we = 1'b0;
        rs_wa = ptr_reg;
        rs_wd = '0;
        rs_ra = start_reg;
        fs_we = 1'b0;
        fs_wa = mv_dst_reg;
        fs_wd = fs_rd;
        fs_ra = scan_reg[FreeW-1:0];
        case (state_reg)
            S_CLEAR:
            begin
                te_we = 1'b1;
                rs_we = 1'b1;
            end
            S_LOC_CHK:
            begin
                te_ra = loc_pos[IdxW-1:0];
                if (req_reg == REQ_SET && !tile_bad && tile_off < 14'(rs_rd)
                    && !loc_pos[IdxW])
                begin
                    te_we = 1'b1;
                    te_wa = loc_pos[IdxW-1:0];
                    te_wd = {1'b1, handle_reg};
                end
            end
            S_AL_SZ: rs_ra = fs_rd;
            S_AL_DONE:
            begin
                if (!best_hit_reg && fresh_end <= (FreshW + 1)'(TableEntries))
                begin
                    rs_we = 1'b1;
                    rs_wa = fresh_reg[IdxW-1:0];
                    rs_wd = need;
                end
                fs_ra = FreeW'(fcount_reg - 1'b1);
            end
            S_AL_MOVE: fs_we = 1'b1;
            S_FR_CLR:
            begin
                te_we = ({1'b0, ptr_reg} < end_reg);
                te_wa = ptr_reg;
            end
            S_FR_SZ:
            begin
                fs_we = 1'b1;
                fs_wa = fcount_reg[FreeW-1:0];
                fs_wd = start_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ptr_reg <= '0;
            fcount_reg <= '0;
            fresh_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // drop the result once taken, unless a new one loads this cycle
            if (out_valid_reg && m_axis_tready && !(state_reg == S_OUT && result_free))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                    if (ptr_reg == IdxW'(TableEntries - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg <= in_req;
                        size_reg <= in_size;
                        start_reg <= in_start;
                        tile_reg <= (in_req == REQ_RES_UV) ? uv_tile : in_tile;
                        handle_reg <= in_handle;
                        st_reg <= ST_OK;
                        ast_reg <= '0;
                        fh_reg <= '0;
                        hv_reg <= 1'b0;
                        scan_reg <= '0;
                        best_hit_reg <= 1'b0;
                        best_size_reg <= '1;
                        case (in_req)
                            REQ_ALLOC: state_reg <= S_AL_RD;
                            REQ_SET, REQ_RES_ID: state_reg <= S_LOC;
                            REQ_RES_UV:
                            begin
                                if (in_u >= UvLimit || in_v >= UvLimit)
                                begin
                                    st_reg <= ST_UV_RANGE;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    state_reg <= S_LOC;
                                end
                            end
                            REQ_FREE:
                            begin
                                if (fcount_reg >= CntW'(FreeSlots))
                                begin
                                    st_reg <= ST_FREE_FULL;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    state_reg <= S_LOC;
                                end
                            end
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                // size read of the start entry is in flight
                S_LOC: state_reg <= S_LOC_WAIT;
                S_LOC_WAIT:
                begin
                    if (req_reg == REQ_FREE)
                    begin
                        state_reg <= S_FR_SZ;
                    end
                    else
                    begin
                        state_reg <= S_LOC_CHK;
                    end
                end
                S_LOC_CHK:
                begin
                    if (tile_bad)
                    begin
                        st_reg <= ST_ILLEGAL_ID;
                        state_reg <= S_OUT;
                    end
                    else if (tile_off >= 14'(rs_rd) || loc_pos[IdxW])
                    begin
                        st_reg <= ST_BEYOND;
                        state_reg <= S_OUT;
                    end
                    else if (req_reg == REQ_SET)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_RES;
                    end
                end
                S_RES:
                begin
                    // entry read issued in S_LOC_CHK; data now valid
                    if (te_rd[EntryW-1])
                    begin
                        fh_reg <= te_rd[15:0];
                        hv_reg <= 1'b1;
                    end
                    else
                    begin
                        st_reg <= ST_EMPTY;
                    end
                    state_reg <= S_OUT;
                end
                S_AL_RD:
                begin
                    if (scan_reg >= fcount_reg ||
                        (best_hit_reg && best_size_reg == (SizeW + 1)'(need)))
                    begin
                        state_reg <= S_AL_DONE;
                    end
                    else
                    begin
                        state_reg <= S_AL_WAIT;
                    end
                end
                S_AL_WAIT: state_reg <= S_AL_SZ;
                S_AL_SZ:
                begin
                    cand_reg <= fs_rd;
                    state_reg <= S_AL_CMP;
                end
                S_AL_CMP:
                begin
                    if (need <= rs_rd && (SizeW + 1)'(rs_rd) < best_size_reg)
                    begin
                        best_reg <= scan_reg[FreeW-1:0];
                        best_hit_reg <= 1'b1;
                        best_size_reg <= (SizeW + 1)'(rs_rd);
                        ast_reg <= cand_reg;
                    end
                    scan_reg <= scan_reg + 1'b1;
                    state_reg <= S_AL_RD;
                end
                S_AL_DONE:
                begin
                    if (best_hit_reg)
                    begin
                        mv_dst_reg <= best_reg;
                        state_reg <= S_AL_MOVE;
                    end
                    else if (fresh_end > (FreshW + 1)'(TableEntries))
                    begin
                        st_reg <= ST_TABLE_FULL;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        ast_reg <= fresh_reg[IdxW-1:0];
                        fresh_reg <= fresh_end[FreshW-1:0];
                        state_reg <= S_OUT;
                    end
                end
                S_AL_MOVE:
                begin
                    // last slot data is valid now and is written to the chosen slot
                    fcount_reg <= fcount_reg - 1'b1;
                    state_reg <= S_OUT;
                end
                S_FR_SZ:
                begin
                    fcount_reg <= fcount_reg + 1'b1;
                    ptr_reg <= start_reg;
                    end_reg <= (({1'b0, start_reg} + (IdxW + 1)'(rs_rd)) >
                                (IdxW + 1)'(TableEntries))
                               ? (IdxW + 1)'(TableEntries)
                               : {1'b0, start_reg} + (IdxW + 1)'(rs_rd);
                    state_reg <= S_FR_CLR;
                end
                S_FR_CLR:
                begin
                    if ({1'b0, ptr_reg} + 1'b1 >= end_reg ||
                        {1'b0, ptr_reg} >= end_reg)
                    begin
                        state_reg <= S_OUT;
                    end
                    ptr_reg <= ptr_reg + 1'b1;
                end
                S_OUT:
                begin
                    if (result_free)
                    begin
                        out_valid_reg <= 1'b1;
                        o_st_reg <= st_reg;
                        o_ast_reg <= ast_reg;
                        o_fh_reg <= fh_reg;
                        o_hv_reg <= hv_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {2'b00, o_hv_reg, o_fh_reg, o_ast_reg, o_st_reg};
endmodule

### tb/tile_range_allocator_checker.sv
`timescale 1ns / 1ps
module tile_range_allocator_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    output int          fail_count,
    output int          pending_count,
    output logic [10:0] fresh_mark
);
    import tra_pkg::*;

    // packed from the highest bit down: status lands in the lowest bits
    typedef struct packed {
        logic        handle_valid;
        logic [15:0] found_handle;
        logic [9:0]  alloc_start;
        logic [2:0]  status;
    } answer_t;

    logic [16:0] entry_mem [TableEntries];
    logic [6:0]  size_mem [TableEntries];
    logic [9:0]  free_list [FreeSlots];
    logic [4:0]  free_cnt;
    logic [10:0] fresh_next;
    answer_t     answer_q [$];

    assign pending_count = answer_q.size();
    assign fresh_mark = fresh_next;

    // Map a tile of a range to a table index; return the status.
    function automatic logic [2:0] find_slot(input logic [9:0] start, input logic [13:0] tile,
                                             output int pos);
        int off;
        pos = 0;
        if (tile < TileFirst || tile > TileLast) return ST_ILLEGAL_ID;
        off = int'(tile) - int'(TileFirst);
        if (off >= int'(size_mem[start])) return ST_BEYOND;
        if (int'(start) + off >= TableEntries) return ST_BEYOND;
        pos = int'(start) + off;
        return ST_OK;
    endfunction

    function automatic answer_t lookup_handle(input logic [9:0] start, input logic [13:0] tile);
        answer_t a;
        int pos;
        a = '0;
        a.status = find_slot(start, tile, pos);
        if (a.status == ST_OK) begin
            if (entry_mem[pos][16]) begin
                a.found_handle = entry_mem[pos][15:0];
                a.handle_valid = 1'b1;
            end else begin
                a.status = ST_EMPTY;
            end
        end
        return a;
    endfunction

    function automatic answer_t apply_request(input logic [63:0] d);
        answer_t a;
        logic [2:0] kind;
        int sz, best, best_sz, pos, stop;
        kind = d[2:0];
        a = '0;
        case (kind)
            REQ_ALLOC: begin
                sz = (d[9:3] == 0) ? 1 : int'(d[9:3]);
                best = FreeSlots;
                best_sz = 1 << 20;
                for (int i = 0; i < free_cnt; i++) begin
                    if (sz <= size_mem[free_list[i]] && size_mem[free_list[i]] < best_sz) begin
                        best = i;
                        best_sz = size_mem[free_list[i]];
                    end
                    if (best_sz == sz) break;
                end
                if (best < FreeSlots) begin
                    a.alloc_start = free_list[best];
                    free_list[best] = free_list[free_cnt - 1];
                    free_cnt--;
                end else if (int'(fresh_next) + sz > TableEntries) begin
                    a.status = ST_TABLE_FULL;
                end else begin
                    size_mem[fresh_next[9:0]] = sz[6:0];
                    a.alloc_start = fresh_next[9:0];
                    fresh_next += sz[10:0];
                end
            end
            REQ_SET: begin
                a.status = find_slot(d[19:10], d[33:20], pos);
                if (a.status == ST_OK) entry_mem[pos] = {1'b1, d[57:42]};
            end
            REQ_FREE: begin
                if (free_cnt >= FreeSlots) begin
                    a.status = ST_FREE_FULL;
                end else begin
                    stop = int'(d[19:10]) + int'(size_mem[d[19:10]]);
                    if (stop > TableEntries) stop = TableEntries;
                    for (int i = int'(d[19:10]); i < stop; i++) entry_mem[i] = '0;
                    free_list[free_cnt[3:0]] = d[19:10];
                    free_cnt++;
                end
            end
            REQ_RES_ID: a = lookup_handle(d[19:10], d[33:20]);
            REQ_RES_UV: begin
                if (d[37:34] >= UvLimit || d[41:38] >= UvLimit) a.status = ST_UV_RANGE;
                else a = lookup_handle(d[19:10],
                                       TileFirst + 14'(d[37:34]) + 14'(d[41:38]) * 14'd10);
            end
            default: ;
        endcase
        return a;
    endfunction

    task automatic report(input string what);
        $display("[%0t] checker: %s", $realtime, what);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        free_cnt = '0;
        fresh_next = '0;
        for (int i = 0; i < TableEntries; i++) begin
            entry_mem[i] = '0;
            size_mem[i] = '0;
        end
    end

    always @(posedge clk) begin
        answer_t got, want;
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[29:0];
                if (m_axis_tdata[31:30] != 0) report("result pad bits not zero");
                if (answer_q.size() == 0) begin
                    report("result transaction with nothing pending");
                end else begin
                    want = answer_q.pop_front();
                    if (got.status != want.status)
                        report($sformatf("status got %0d want %0d", got.status, want.status));
                    if (got.alloc_start != want.alloc_start)
                        report($sformatf("alloc_start got %0d want %0d",
                                         got.alloc_start, want.alloc_start));
                    if (got.found_handle != want.found_handle)
                        report($sformatf("found_handle got %h want %h",
                                         got.found_handle, want.found_handle));
                    if (got.handle_valid != want.handle_valid)
                        report("handle_valid mismatch");
                end
            end
            // Predict after popping so a same-edge request never satisfies itself.
            if (s_axis_tvalid && s_axis_tready)
                answer_q = {answer_q, apply_request(s_axis_tdata)};
        end
    end
endmodule

### tb/tile_range_allocator_top_tb.sv
`timescale 1ns / 1ps
module tile_range_allocator_top_tb;
    import tra_pkg::*;

    localparam int RandomRequests = 1750;
    localparam int StallLimit = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    int          fail_count;
    int          pending_count;
    logic [10:0] fresh_mark;
    int          idle_cycles;
    logic [9:0]  known_starts [$];

    tile_range_allocator_top dut (.*);

    tile_range_allocator_checker checker_i (.*);

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Stall the result side in runs of a random mode: free flow, random drops, or mostly stalled.
    initial begin
        int mode;
        m_axis_tready = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(5, 60)) begin
                @(negedge clk);
                m_axis_tready <= (mode == 0) ? 1'b1 : (mode == 1) ? ($urandom_range(0, 3) != 0)
                                 : ($urandom_range(0, 4) == 0);
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= StallLimit) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic logic [63:0] pack_request(input logic [2:0] kind, input logic [6:0] sz,
                                                 input logic [9:0] start, input logic [13:0] tile,
                                                 input logic [3:0] u, input logic [3:0] v,
                                                 input logic [15:0] handle);
        return {6'd0, handle, v, u, tile, start, sz, kind};
    endfunction

    // Hold one request until it is accepted.
    task automatic send_request(input logic [63:0] d);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic pause_sender(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    function automatic logic [9:0] pick_start();
        if (known_starts.size() != 0 && $urandom_range(0, 9) != 0)
            return known_starts[$urandom_range(0, known_starts.size() - 1)];
        return 10'($urandom);
    endfunction

    // Mostly legal traffic on recorded ranges, with a tail of junk fields.
    function automatic logic [63:0] random_request();
        logic [2:0]  kind;
        logic [6:0]  sz;
        logic [13:0] tile;
        logic [3:0]  u, v;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 14)      kind = REQ_ALLOC;
        else if (pick < 44) kind = REQ_SET;
        else if (pick < 54) kind = REQ_FREE;
        else if (pick < 76) kind = REQ_RES_ID;
        else if (pick < 97) kind = REQ_RES_UV;
        else                kind = 3'($urandom_range(5, 7));
        sz = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 12));
        tile = ($urandom_range(0, 9) == 0) ? 14'($urandom)
               : TileFirst + 14'($urandom_range(0, 13));
        u = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
        v = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 1));
        return pack_request(kind, sz, pick_start(), tile, u, v, 16'($urandom));
    endfunction

    initial begin
        logic [63:0] req;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        rst_n = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed part: field extremes, each request kind and each corner.
        send_request(pack_request(REQ_ALLOC, 7'd0, '0, '0, '0, '0, '0));      // size zero
        send_request(pack_request(REQ_ALLOC, 7'd127, '0, '0, '0, '0, '0));
        send_request(pack_request(REQ_ALLOC, 7'd20, '0, '0, '0, '0, '0));
        send_request(pack_request(REQ_SET, '0, 10'd1, 14'd1001, '0, '0, 16'hFFFF));
        send_request(pack_request(REQ_SET, '0, 10'd1, 14'd1127, '0, '0, 16'h0000));
        send_request(pack_request(REQ_SET, '0, 10'd128, 14'd1020, '0, '0, 16'hA5A5));
        send_request(pack_request(REQ_SET, '0, 10'd128, 14'd1000, '0, '0, 16'h1234));
        send_request(pack_request(REQ_SET, '0, 10'd128, 14'd16383, '0, '0, 16'h1234));
        send_request(pack_request(REQ_SET, '0, 10'd128, 14'd1021, '0, '0, 16'h1234));
        send_request(pack_request(REQ_RES_ID, '0, 10'd128, 14'd1020, '0, '0, '0));
        send_request(pack_request(REQ_RES_ID, '0, 10'd128, 14'd1019, '0, '0, '0));
        send_request(pack_request(REQ_RES_UV, '0, 10'd1, '0, 4'd0, 4'd0, '0));
        send_request(pack_request(REQ_RES_UV, '0, 10'd1, '0, 4'd15, 4'd0, '0));
        send_request(pack_request(REQ_RES_UV, '0, 10'd1, '0, 4'd0, 4'd10, '0));
        send_request(pack_request(REQ_RES_UV, '0, 10'd1, '0, 4'd9, 4'd9, '0));
        send_request(pack_request(REQ_FREE, '0, 10'd1, '0, '0, '0, '0));
        send_request(pack_request(REQ_FREE, '0, 10'd1023, '0, '0, '0, '0));   // never allocated
        send_request(pack_request(REQ_ALLOC, 7'd5, '0, '0, '0, '0, '0));      // reuse keeps size
        send_request(pack_request(REQ_RES_ID, '0, 10'd1, 14'd1001, '0, '0, '0));
        send_request(pack_request(3'd5, 7'h7F, 10'h3FF, 14'h3FFF, 4'hF, 4'hF, 16'hFFFF));
        send_request(pack_request(3'd7, '0, '0, '0, '0, '0, '0));
        // Drain so every result is back before the random part.
        pause_sender(0);
        while (pending_count != 0) @(negedge clk);

        known_starts = '{10'd0, 10'd1, 10'd128, 10'd148};
        for (int n = 0; n < RandomRequests; n++) begin
            req = random_request();
            // Exhaust the table late in the run so table full gets exercised.
            if (n > RandomRequests * 3 / 4 && req[2:0] == REQ_ALLOC) req[9:3] = 7'd100;
            if (req[2:0] == REQ_ALLOC && fresh_mark < TableEntries)
                known_starts = {known_starts, fresh_mark[9:0]};
            if (known_starts.size() > 64) void'(known_starts.pop_front());
            send_request(req);
            // Gaps between bursts of random length, sometimes a full drain.
            if ($urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 40));
            if ($urandom_range(0, 99) == 0) begin
                pause_sender(0);
                while (pending_count != 0) @(negedge clk);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_count != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
